/* src/assert_macros.svh */
// Assertion macros for the page free list allocator checker.
// Standalone header; expects a signal named clock and one named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, ignored while reset is high.
`define PFLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included.
`define PFLA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/pfla_pkg.sv */
// Shared types, codes and sizes of the page free list allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package pfla_pkg;

   localparam int ADDR_W     = 32;
   localparam int PAGE_BYTES = 4096;
   localparam int MAX_PAGES  = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PN_W       = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int CNT_W      = 13;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int WIDE_W     = ADDR_W + 2;

   localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};
   localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(32'hFFFF_F000);

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_LIMIT   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] page_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   given_page;
      logic [CNT_W-1:0]    free_count;
      logic [CNT_W-1:0]    total_count;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic                init_setup;
      logic                init_clear;
      logic                fill_write;
      logic                pop;
      logic                push;
      logic                respond;
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              ready;
      logic              head_zero;
      logic              init_too_small;
      logic              init_empty;
      logic              free_ok;
      logic              fill_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/pfla_ctrl.sv */
// Controller of the page free list allocator: sequences each word.
// Depends on pfla_pkg; drives the commands of pfla_datapath.
`default_nettype none

module pfla_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   input  wire pfla_pkg::dp_status_type status,
   output pfla_pkg::dp_cmd_type        cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FILL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in    = S_IDLE;
            cmd.respond = 1'b1;
            unique case (status.func)
               pfla_pkg::FUNC_INIT: begin
                  priority if (status.init_too_small) begin
                     cmd.rsp_status = pfla_pkg::ST_TOO_SMALL;
                  end else if (status.init_empty) begin
                     cmd.init_clear = 1'b1;
                     cmd.rsp_status = pfla_pkg::ST_TOO_SMALL;
                  end else begin
                     cmd.init_setup = 1'b1;
                     cmd.respond    = 1'b0;
                     state_in       = S_FILL;
                  end
               end
               pfla_pkg::FUNC_ALLOC: begin
                  priority if (!status.ready) begin
                     cmd.rsp_status = pfla_pkg::ST_NOT_READY;
                  end else if (status.head_zero) begin
                     cmd.rsp_status = pfla_pkg::ST_EMPTY;
                  end else begin
                     cmd.pop        = 1'b1;
                     cmd.rsp_status = pfla_pkg::ST_OK;
                  end
               end
               pfla_pkg::FUNC_FREE: begin
                  priority if (!status.ready) begin
                     cmd.rsp_status = pfla_pkg::ST_NOT_READY;
                  end else if (!status.free_ok) begin
                     cmd.rsp_status = pfla_pkg::ST_REJECTED;
                  end else begin
                     cmd.push       = 1'b1;
                     cmd.rsp_status = pfla_pkg::ST_OK;
                  end
               end
               default: begin
                  cmd.rsp_status = pfla_pkg::ST_OK;
               end
            endcase
         end
         S_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = pfla_pkg::ST_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/pfla_datapath.sv */
// Datapath of the page free list allocator: registers, link memory, checks.
// Depends on pfla_pkg; commanded by pfla_ctrl.
`default_nettype none

module pfla_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pfla_pkg::req_type           req_data,
   output pfla_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_write,
   input  wire logic [pfla_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pfla_pkg::ADDR_W-1:0]    csr_wdata,
   input  wire pfla_pkg::dp_cmd_type        cmd,
   output pfla_pkg::dp_status_type          status
);

   localparam logic [pfla_pkg::WIDE_W-1:0] MASK_W =
      pfla_pkg::WIDE_W'(pfla_pkg::PAGE_BYTES - 1);
   localparam logic [pfla_pkg::WIDE_W-1:0] PAGE_W =
      pfla_pkg::WIDE_W'(pfla_pkg::PAGE_BYTES);
   localparam logic [pfla_pkg::WIDE_W-1:0] CAP_W =
      pfla_pkg::WIDE_W'(pfla_pkg::MAX_PAGES) << pfla_pkg::PAGE_SHIFT;
   localparam logic [pfla_pkg::PN_W-1:0] MAX_PN =
      pfla_pkg::PN_W'(pfla_pkg::MAX_PAGES);

   logic [pfla_pkg::ADDR_W-1:0] arena_low_ff;
   logic [pfla_pkg::ADDR_W-1:0] arena_high_ff;
   logic [pfla_pkg::ADDR_W-1:0] limit_ff;

   logic [pfla_pkg::PN_W-1:0]   head_ff, head_in;
   logic [pfla_pkg::CNT_W-1:0]  free_ff, free_in;
   logic [pfla_pkg::CNT_W-1:0]  total_ff, total_in;
   logic                        ready_ff, ready_in;
   logic [pfla_pkg::PN_W-1:0]   base_ff, base_in;
   logic [pfla_pkg::PN_W-1:0]   end_ff, end_in;

   pfla_pkg::req_type           req_ff;
   pfla_pkg::rsp_type           rsp_ff, rsp_in;
   logic [pfla_pkg::IDX_W-1:0]  fill_idx_ff;
   logic [pfla_pkg::PN_W-1:0]   link_rd_ff;

   logic [pfla_pkg::PN_W-1:0]   link_mem [pfla_pkg::MAX_PAGES];

   logic [pfla_pkg::WIDE_W-1:0] lo_sum, lo, hi, lim, hi_clamp, hi_cap, cap, span;
   logic [pfla_pkg::CNT_W-1:0]  init_n;
   logic [pfla_pkg::PN_W-1:0]   init_base, init_end;
   logic [pfla_pkg::PN_W-1:0]   head_off, free_pn, free_off, fill_data;
   logic                        head_in_range;
   logic                        mem_we;
   logic [pfla_pkg::IDX_W-1:0]  mem_waddr;
   logic [pfla_pkg::PN_W-1:0]   mem_wdata;

   // arena bounds for init
   always_comb begin
      lo_sum    = pfla_pkg::WIDE_W'(arena_low_ff) + MASK_W;
      lo        = lo_sum & ~MASK_W;
      hi        = pfla_pkg::WIDE_W'(arena_high_ff) & ~MASK_W;
      lim       = pfla_pkg::WIDE_W'(limit_ff) & ~MASK_W;
      cap       = lo + CAP_W;
      hi_clamp  = (hi > pfla_pkg::WIDE_W'(limit_ff)) ? lim : hi;
      hi_cap    = (hi_clamp > cap) ? cap : hi_clamp;
      span      = hi_cap - lo;
      init_n    = (hi_cap > lo) ? span[pfla_pkg::PAGE_SHIFT +: pfla_pkg::CNT_W] : '0;
      init_base = lo[pfla_pkg::PAGE_SHIFT +: pfla_pkg::PN_W];
      init_end  = hi_cap[pfla_pkg::PAGE_SHIFT +: pfla_pkg::PN_W];
   end

   assign head_off      = head_ff - base_ff;
   assign head_in_range = (head_ff >= base_ff) && (head_off < MAX_PN);
   assign free_pn       = req_ff.page_address[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT];
   assign free_off      = free_pn - base_ff;
   assign fill_data     = (fill_idx_ff == '0) ? '0
                        : base_ff + pfla_pkg::PN_W'(fill_idx_ff) - pfla_pkg::PN_W'(1);

   always_comb begin
      status.func           = req_ff.func;
      status.ready          = ready_ff;
      status.head_zero      = (head_ff == '0);
      status.init_too_small = (hi <= lo + PAGE_W);
      status.init_empty     = (init_n == '0);
      status.free_ok        = (req_ff.page_address != '0)
                           && (free_pn >= base_ff) && (free_pn < end_ff)
                           && (req_ff.page_address[pfla_pkg::PAGE_SHIFT-1:0] == '0);
      status.fill_last      = (pfla_pkg::CNT_W'(fill_idx_ff)
                               == total_ff - pfla_pkg::CNT_W'(1));
   end

   always_comb begin
      head_in  = head_ff;
      free_in  = free_ff;
      total_in = total_ff;
      ready_in = ready_ff;
      base_in  = base_ff;
      end_in   = end_ff;
      if (cmd.init_setup) begin
         head_in  = init_base + pfla_pkg::PN_W'(init_n) - pfla_pkg::PN_W'(1);
         free_in  = init_n;
         total_in = init_n;
         ready_in = 1'b1;
         base_in  = init_base;
         end_in   = init_end;
      end
      if (cmd.init_clear) begin
         head_in  = '0;
         free_in  = '0;
         total_in = '0;
         ready_in = 1'b0;
         base_in  = init_base;
         end_in   = init_end;
      end
      if (cmd.pop) begin
         head_in = head_in_range ? link_rd_ff : '0;
         if (free_ff != '0) begin
            free_in = free_ff - pfla_pkg::CNT_W'(1);
         end
      end
      if (cmd.push) begin
         head_in = free_pn;
         if (free_ff < pfla_pkg::COUNT_SAT) begin
            free_in = free_ff + pfla_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in.status      = cmd.rsp_status;
      rsp_in.given_page  = cmd.pop ? {head_ff, {pfla_pkg::PAGE_SHIFT{1'b0}}} : '0;
      rsp_in.free_count  = free_in;
      rsp_in.total_count = total_in;
   end

   assign mem_we    = cmd.fill_write || cmd.push;
   assign mem_waddr = cmd.fill_write ? fill_idx_ff : free_off[pfla_pkg::IDX_W-1:0];
   assign mem_wdata = cmd.fill_write ? fill_data : head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_low_ff  <= '0;
         arena_high_ff <= '0;
         limit_ff      <= pfla_pkg::LIMIT_RESET;
         head_ff       <= '0;
         free_ff       <= '0;
         total_ff      <= '0;
         ready_ff      <= 1'b0;
         base_ff       <= '0;
         end_ff        <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               pfla_pkg::CSR_ARENA_LOW:  arena_low_ff  <= csr_wdata;
               pfla_pkg::CSR_ARENA_HIGH: arena_high_ff <= csr_wdata;
               pfla_pkg::CSR_ID_LIMIT:   limit_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
         head_ff  <= head_in;
         free_ff  <= free_in;
         total_ff <= total_in;
         ready_ff <= ready_in;
         base_ff  <= base_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req_data;
         link_rd_ff <= link_mem[head_off[pfla_pkg::IDX_W-1:0]];
      end
      if (cmd.init_setup) begin
         fill_idx_ff <= '0;
      end else if (cmd.fill_write) begin
         fill_idx_ff <= fill_idx_ff + pfla_pkg::IDX_W'(1);
      end
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* src/page_free_list_allocator.sv */
// Top level of the page free list allocator.
// Depends on pfla_pkg, pfla_ctrl and pfla_datapath.
//
// Usage:
//   Request: drive req_data and raise start; the word is taken at a clock
//   edge with start high and busy low. func selects init, allocate, free or no-op.
//   Response: rsp_valid pulses for one cycle with rsp_data (status, page,
//   free and total counts). The receiver cannot stall; rsp_data holds until
//   the next response, but rsp_valid is low after that cycle.
//   Configuration: csr_valid with csr_index and csr_wdata; csr_ready is
//   always high. Write only while busy is low and no response is pending.
// Timing:
//   Allocate, free and no-op: the word is handled in S_EXEC and rsp_valid is
//   registered from it; busy is low while rsp_valid is high, so the next word can be taken then.
//   The link memory read for allocate is issued at the accepting edge.
//   Init: S_EXEC, then S_FILL writes one link entry per page of the arena, one write per
//   cycle through the single write port. A refused init responds from S_EXEC.
// Reset:
//   Synchronous, active high. Clears the list (not initialized) and sets
//   the bound registers to their defaults; the link memory is not cleared.
`default_nettype none

module page_free_list_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire pfla_pkg::req_type              req_data,
   output logic                                rsp_valid,
   output pfla_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pfla_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pfla_pkg::ADDR_W-1:0]    csr_wdata
);

   pfla_pkg::dp_cmd_type    cmd;
   pfla_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   pfla_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

/* src/pfla_checker.sv */
// Port-level checks of the page free list allocator, bound to the top level.
// Depends on pfla_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pfla_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire pfla_pkg::rsp_type rsp_data
);

   `PFLA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `PFLA_ASSERT(a_rsp_idle, rsp_valid |-> !busy, "busy during response cycle")
   `PFLA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "response strobe longer than one cycle")
   `PFLA_ASSERT(a_page_ok, (rsp_valid && (rsp_data.status != pfla_pkg::ST_OK)) |-> (rsp_data.given_page == '0), "page returned with error status")
   `PFLA_ASSERT_RST(a_reset_idle, reset |=> (!busy && !rsp_valid), "not idle after reset")

endmodule

bind page_free_list_allocator pfla_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
